// File: rtl/core/gshare_branch_predictor_unit_macros.svh
// Assertion macros used by the checker file of the branch predictor.
`ifndef GSHARE_BRANCH_PREDICTOR_UNIT_MACROS_SVH
`define GSHARE_BRANCH_PREDICTOR_UNIT_MACROS_SVH

// The consequent must hold in every cycle in which the antecedent holds.
`define GBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never hold outside reset.
`define GBP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// File: rtl/core/gbp_pkg.sv
package gbp_pkg;

	localparam int INDEX_BITS_DEF    = 18;
	localparam int ADDRESS_SHIFT_DEF = 3;
	localparam int COUNT_BITS_DEF    = 32;

	localparam int ADDR_W  = 32;
	localparam int TOTAL_W = 32;
	localparam int CTR_W   = 2;

	typedef logic [CTR_W-1:0] ctr_t;

	localparam ctr_t CTR_MIN       = 2'b00;
	localparam ctr_t CTR_MAX       = 2'b11;
	localparam int   CTR_TAKEN_BIT = 1;

	typedef struct packed {
		logic [ADDR_W-1:0] branch_address;
		logic              taken;
	} gbp_in_t;

	typedef struct packed {
		logic               predicted_taken;
		logic               mispredicted;
		logic [TOTAL_W-1:0] branch_total;
		logic [TOTAL_W-1:0] miss_total;
	} gbp_out_t;

endpackage

// File: rtl/core/gbp_ram.sv
module gbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/gbp_clear.sv
module gbp_clear #(
	parameter int INDEX_BITS = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	output logic                  active,
	output logic [INDEX_BITS-1:0] addr
);

	logic                  active_q;
	logic [INDEX_BITS-1:0] addr_q;

	// Sweeps every table entry once after reset, writing strongly not taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			addr_q   <= '0;
		end else if (active_q) begin
			addr_q <= addr_q + 1'b1;
			if (addr_q == '1) begin
				active_q <= 1'b0;
			end
		end
	end

	assign active = active_q;
	assign addr   = addr_q;

endmodule

// File: rtl/core/gbp_update.sv
module gbp_update #(
	parameter int INDEX_BITS = 18,
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_s1,
	input  logic [INDEX_BITS-1:0] idx_s1,
	input  logic                  taken_s1,
	input  gbp_pkg::ctr_t         rdata,
	output logic                  we,
	output logic [INDEX_BITS-1:0] waddr,
	output gbp_pkg::ctr_t         wdata,
	output logic                  done,
	output gbp_pkg::gbp_out_t     result
);

	import gbp_pkg::*;

	logic                  fwd_vld_q;
	logic [INDEX_BITS-1:0] fwd_idx_q;
	ctr_t                  fwd_ctr_q;
	logic [COUNT_BITS-1:0] br_q;
	logic [COUNT_BITS-1:0] miss_q;
	logic                  done_q;
	gbp_out_t              result_q;

	ctr_t                  ctr_cur;
	ctr_t                  ctr_nxt;
	logic                  pred;
	logic                  miss;
	logic [COUNT_BITS-1:0] br_nxt;
	logic [COUNT_BITS-1:0] miss_nxt;

	always_comb begin
		// The RAM returns stale data when the previous transaction wrote the
		// same entry in the cycle of this read, so the latest write wins.
		ctr_cur = (fwd_vld_q && (fwd_idx_q == idx_s1)) ? fwd_ctr_q : rdata;
		pred    = ctr_cur[CTR_TAKEN_BIT];
		miss    = pred ^ taken_s1;
		if (taken_s1) begin
			ctr_nxt = (ctr_cur != CTR_MAX) ? ctr_cur + 2'd1 : ctr_cur;
		end else begin
			ctr_nxt = (ctr_cur != CTR_MIN) ? ctr_cur - 2'd1 : ctr_cur;
		end
		br_nxt   = (br_q == '1) ? br_q : br_q + 1'b1;
		miss_nxt = (miss && (miss_q != '1)) ? miss_q + 1'b1 : miss_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
			br_q      <= '0;
			miss_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= vld_s1;
			if (vld_s1) begin
				fwd_vld_q <= 1'b1;
				br_q      <= br_nxt;
				miss_q    <= miss_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			fwd_idx_q                <= idx_s1;
			fwd_ctr_q                <= ctr_nxt;
			result_q.predicted_taken <= pred;
			result_q.mispredicted    <= miss;
			result_q.branch_total    <= TOTAL_W'(br_nxt);
			result_q.miss_total      <= TOTAL_W'(miss_nxt);
		end
	end

	assign we     = vld_s1;
	assign waddr  = idx_s1;
	assign wdata  = ctr_nxt;
	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/core/gshare_branch_predictor_unit.sv
// Channel   Signals                 Handshake
// --------  ----------------------  ------------------------------------------
// branch    start, busy, branch     transaction taken when start && !busy
// result    done, result            one-cycle strobe, cannot be held off
//
// One branch is accepted per cycle while busy is low; its result is registered
// through the counter table read and then the output register.
// The counter table is a single-port-read, single-port-write RAM; a write that
// coincides with a read of the same entry is forwarded.
// After reset, busy stays high while all 2**INDEX_BITS table entries are
// swept to strongly not taken; no branch is accepted during that sweep.
// busy is low at all other times, since the receiver never stalls.
module gshare_branch_predictor_unit #(
	parameter int INDEX_BITS    = gbp_pkg::INDEX_BITS_DEF,
	parameter int ADDRESS_SHIFT = gbp_pkg::ADDRESS_SHIFT_DEF,
	parameter int COUNT_BITS    = gbp_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gbp_pkg::gbp_in_t  branch,
	output logic              done,
	output gbp_pkg::gbp_out_t result
);

	import gbp_pkg::*;

	localparam int DEPTH = 1 << INDEX_BITS;

	logic                  clr_active;
	logic [INDEX_BITS-1:0] clr_addr;

	logic [INDEX_BITS-1:0] history_q;
	logic                  vld_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic                  taken_s1;

	logic                  accept;
	logic [ADDR_W-1:0]     addr_sh;
	logic [INDEX_BITS-1:0] idx;

	logic                  upd_we;
	logic [INDEX_BITS-1:0] upd_waddr;
	ctr_t                  upd_wdata;
	ctr_t                  ram_rdata;

	logic                  ram_we;
	logic [INDEX_BITS-1:0] ram_waddr;
	ctr_t                  ram_wdata;

	assign busy    = clr_active;
	assign accept  = start && !clr_active;
	assign addr_sh = branch.branch_address >> ADDRESS_SHIFT;
	assign idx     = history_q ^ addr_sh[INDEX_BITS-1:0];

	// History moves at acceptance so the next branch can index right away.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				history_q <= {history_q[INDEX_BITS-2:0], branch.taken};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= idx;
			taken_s1 <= branch.taken;
		end
	end

	gbp_clear #(
		.INDEX_BITS(INDEX_BITS)
	) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.active (clr_active),
		.addr   (clr_addr)
	);

	assign ram_we    = clr_active || upd_we;
	assign ram_waddr = clr_active ? clr_addr : upd_waddr;
	assign ram_wdata = clr_active ? CTR_MIN : upd_wdata;

	gbp_ram #(
		.WIDTH(CTR_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	gbp_update #(
		.INDEX_BITS(INDEX_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.idx_s1   (idx_s1),
		.taken_s1 (taken_s1),
		.rdata    (ram_rdata),
		.we       (upd_we),
		.waddr    (upd_waddr),
		.wdata    (upd_wdata),
		.done     (done),
		.result   (result)
	);

endmodule

// File: rtl/core/gbp_checker.sv
`include "gshare_branch_predictor_unit_macros.svh"

module gbp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input gbp_pkg::gbp_in_t  branch,
	input logic              done,
	input gbp_pkg::gbp_out_t result
);

	// Every result belongs to an accepted transaction, passed through the table read and the output register.
	`GBP_ASSERT_IMPL(a_done_follows_accept, clk, arst_n, done, $past(start && !busy, 2), "result without a matching transaction")

	// The miss flag compares the prediction with the outcome of that transaction.
	`GBP_ASSERT_IMPL(a_miss_flag, clk, arst_n, done, result.mispredicted == (result.predicted_taken ^ $past(branch.taken, 2)), "mispredict flag disagrees with outcome")

	// Nothing is in flight while the table sweep holds the block busy.
	`GBP_ASSERT_NEVER(a_no_result_while_busy, clk, arst_n, busy && done, "result during table sweep")

	// The sweep only runs once after reset.
	`GBP_ASSERT_NEVER(a_busy_no_rise, clk, arst_n, $rose(busy), "busy rose outside reset")

endmodule

bind gshare_branch_predictor_unit gbp_checker u_gbp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.branch (branch),
	.done   (done),
	.result (result)
);
